// ===== design/assert_macros.svh =====
// assertion macros used by edid base block scan and top modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/edid_bp_pkg.sv =====
// types and constants of the edid base block parser
`timescale 1ns / 1ps
`default_nettype none

package edid_bp_pkg;

    localparam int TEXT_LEN      = 13;
    localparam int TEXT_OFS      = 5;
    localparam int DESC_SIZE     = 18;
    localparam int DESC_START    = 54;
    localparam int DESC_END      = DESC_START + 4 * DESC_SIZE;
    localparam int BLOCK_LEN     = 128;

    localparam logic [7:0] HDR_BYTE0  = 8'h00;
    localparam logic [7:0] HDR_BYTE1  = 8'hFF;
    localparam logic [7:0] TAG_NAME   = 8'hFC;
    localparam logic [7:0] TAG_SERIAL = 8'hFF;

    localparam int OUT_BITS  = 267;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_NAME   = 2'd1,
        KIND_SERIAL = 2'd2,
        KIND_PREFIX = 2'd3
    } t_kind;

    typedef logic [TEXT_LEN-1:0][7:0] t_text;

    typedef struct packed {
        logic        full_ok;
        logic [15:0] maker_raw;
        logic [15:0] size_raw;
        logic        name_found;
        logic [3:0]  name_cnt;
        t_text       name_text;
        logic        serial_found;
        logic [3:0]  serial_cnt;
        t_text       serial_text;
    } t_snap;

    typedef struct packed {
        logic        header_ok;
        logic [23:0] maker_letters;
        logic [11:0] width_mm;
        logic [11:0] height_mm;
        logic        name_found;
        logic [63:0] name_head;
        logic [39:0] name_tail;
        logic [3:0]  name_length;
        logic        serial_found;
        logic [63:0] serial_head;
        logic [39:0] serial_tail;
        logic [3:0]  serial_length;
    } t_result;

endpackage

`default_nettype wire

// ===== design/edid_bp_scan.sv =====
// byte position tracking, header check, field capture and descriptor scan
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module edid_bp_scan (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_take,
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_last,
    output edid_bp_pkg::t_snap       o_snap
);

    localparam logic [7:0] POS_FULL  = 8'(edid_bp_pkg::BLOCK_LEN);
    localparam logic [7:0] POS_FINAL = 8'(edid_bp_pkg::BLOCK_LEN - 1);
    localparam logic [7:0] POS_DESC0 = 8'(edid_bp_pkg::DESC_START);
    localparam logic [7:0] POS_DESCE = 8'(edid_bp_pkg::DESC_END);
    localparam logic [4:0] OFS_LAST  = 5'(edid_bp_pkg::DESC_SIZE - 1);
    localparam logic [4:0] OFS_TEXT  = 5'(edid_bp_pkg::TEXT_OFS);

    logic [7:0]              r_pos,          n_pos;
    logic [4:0]              r_ofs,          n_ofs;
    logic                    r_header,       n_header;
    logic [15:0]             r_maker,        n_maker;
    logic [15:0]             r_size,         n_size;
    edid_bp_pkg::t_kind      r_kind,         n_kind;
    edid_bp_pkg::t_text      r_desc_text,    n_desc_text;
    edid_bp_pkg::t_text      r_name_text,    n_name_text;
    edid_bp_pkg::t_text      r_serial_text,  n_serial_text;
    logic                    r_name_found,   n_name_found;
    logic                    r_serial_found, n_serial_found;
    logic [3:0]              r_name_cnt,     n_name_cnt;
    logic [3:0]              r_serial_cnt,   n_serial_cnt;

    logic                    w_in_block;
    logic                    w_in_desc;
    logic [3:0]              w_text_idx;
    edid_bp_pkg::t_text      w_cur_text;
    logic [3:0]              w_cur_len;

    // cut at first zero, then trim trailing space, lf and cr
    function automatic logic [3:0] text_len(input edid_bp_pkg::t_text t);
        logic       alive;
        logic [3:0] len;
        alive = 1'b1;
        len   = 4'd0;
        for (int i = 0; i < edid_bp_pkg::TEXT_LEN; i++) begin
            alive = alive & (t[i] != 8'h00);
            if (alive && t[i] != 8'h20 && t[i] != 8'h0A && t[i] != 8'h0D) begin
                len = 4'(i + 1);
            end
        end
        return len;
    endfunction

    assign w_in_block = (r_pos < POS_FULL);
    assign w_in_desc  = (r_pos >= POS_DESC0) && (r_pos < POS_DESCE);
    assign w_text_idx = 4'(r_ofs - OFS_TEXT);

    always_comb begin
        w_cur_text     = r_desc_text;
        w_cur_text[edid_bp_pkg::TEXT_LEN-1] = i_byte;
        w_cur_len      = text_len(w_cur_text);
    end

    always_comb begin
        n_pos          = r_pos;
        n_ofs          = r_ofs;
        n_header       = r_header;
        n_maker        = r_maker;
        n_size         = r_size;
        n_kind         = r_kind;
        n_desc_text    = r_desc_text;
        n_name_text    = r_name_text;
        n_serial_text  = r_serial_text;
        n_name_found   = r_name_found;
        n_serial_found = r_serial_found;
        n_name_cnt     = r_name_cnt;
        n_serial_cnt   = r_serial_cnt;
        if (i_take && i_last) begin
            n_pos          = 8'd0;
            n_ofs          = 5'd0;
            n_header       = 1'b0;
            n_kind         = edid_bp_pkg::KIND_NONE;
            n_name_found   = 1'b0;
            n_serial_found = 1'b0;
            n_name_cnt     = 4'd0;
            n_serial_cnt   = 4'd0;
        end else if (i_take && w_in_block) begin
            n_pos = r_pos + 8'd1;
            case (r_pos)
                8'd0:    n_header = (i_byte == edid_bp_pkg::HDR_BYTE0);
                8'd1:    n_header = r_header && (i_byte == edid_bp_pkg::HDR_BYTE1);
                8'd8:    n_maker[15:8] = i_byte;
                8'd9:    n_maker[7:0]  = i_byte;
                8'd21:   n_size[15:8]  = i_byte;
                8'd22:   n_size[7:0]   = i_byte;
                default: ;
            endcase
            if (w_in_desc) begin
                n_ofs = (r_ofs == OFS_LAST) ? 5'd0 : r_ofs + 5'd1;
                case (r_ofs)
                    5'd0: begin
                        n_kind = (i_byte == 8'h00) ? edid_bp_pkg::KIND_PREFIX
                                                   : edid_bp_pkg::KIND_NONE;
                    end
                    5'd1, 5'd2: begin
                        if (!(r_kind == edid_bp_pkg::KIND_PREFIX && i_byte == 8'h00)) begin
                            n_kind = edid_bp_pkg::KIND_NONE;
                        end
                    end
                    5'd3: begin
                        if (r_kind == edid_bp_pkg::KIND_PREFIX &&
                            i_byte == edid_bp_pkg::TAG_NAME) begin
                            n_kind = edid_bp_pkg::KIND_NAME;
                        end else if (r_kind == edid_bp_pkg::KIND_PREFIX &&
                                     i_byte == edid_bp_pkg::TAG_SERIAL) begin
                            n_kind = edid_bp_pkg::KIND_SERIAL;
                        end else begin
                            n_kind = edid_bp_pkg::KIND_NONE;
                        end
                    end
                    5'd4: ;
                    default: begin
                        n_desc_text[w_text_idx] = i_byte;
                        if (r_ofs == OFS_LAST) begin
                            if (r_kind == edid_bp_pkg::KIND_NAME) begin
                                n_name_text  = w_cur_text;
                                n_name_found = 1'b1;
                                n_name_cnt   = w_cur_len;
                            end else if (r_kind == edid_bp_pkg::KIND_SERIAL) begin
                                n_serial_text  = w_cur_text;
                                n_serial_found = 1'b1;
                                n_serial_cnt   = w_cur_len;
                            end
                            n_kind = edid_bp_pkg::KIND_NONE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos          <= 8'd0;
            r_ofs          <= 5'd0;
            r_header       <= 1'b0;
            r_kind         <= edid_bp_pkg::KIND_NONE;
            r_name_found   <= 1'b0;
            r_serial_found <= 1'b0;
            r_name_cnt     <= 4'd0;
            r_serial_cnt   <= 4'd0;
        end else begin
            r_pos          <= n_pos;
            r_ofs          <= n_ofs;
            r_header       <= n_header;
            r_kind         <= n_kind;
            r_name_found   <= n_name_found;
            r_serial_found <= n_serial_found;
            r_name_cnt     <= n_name_cnt;
            r_serial_cnt   <= n_serial_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_maker       <= n_maker;
        r_size        <= n_size;
        r_desc_text   <= n_desc_text;
        r_name_text   <= n_name_text;
        r_serial_text <= n_serial_text;
    end

    // block is complete once the current byte is position 127 or later
    always_comb begin
        o_snap.full_ok      = ((r_pos == POS_FINAL) || !w_in_block) && r_header;
        o_snap.maker_raw    = r_maker;
        o_snap.size_raw     = r_size;
        o_snap.name_found   = r_name_found;
        o_snap.name_cnt     = r_name_cnt;
        o_snap.name_text    = r_name_text;
        o_snap.serial_found = r_serial_found;
        o_snap.serial_cnt   = r_serial_cnt;
        o_snap.serial_text  = r_serial_text;
    end

    `ASSERT_HOLDS(a_pos_sat, i_clk, i_rst_n, r_pos <= POS_FULL)
    `ASSERT_IMPLIES(a_ofs_region, i_clk, i_rst_n, r_ofs != 5'd0,
                    r_pos > POS_DESC0 && r_pos < POS_DESCE)
    `ASSERT_IMPLIES(a_prefix_ofs, i_clk, i_rst_n, r_kind == edid_bp_pkg::KIND_PREFIX,
                    r_ofs >= 5'd1 && r_ofs <= 5'd3)

endmodule

`default_nettype wire

// ===== design/edid_bp_fmt.sv =====
// result formatting and the result register
`timescale 1ns / 1ps
`default_nettype none

module edid_bp_fmt (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic                i_ready,
    input  edid_bp_pkg::t_snap       i_snap,
    output logic                     o_valid,
    output edid_bp_pkg::t_result     o_result
);

    logic                  r_valid, n_valid;
    edid_bp_pkg::t_result  r_result, n_result;
    logic                  w_ok;
    logic [3:0]            w_name_cnt;
    logic [3:0]            w_serial_cnt;

    function automatic logic [63:0] pack_head(input edid_bp_pkg::t_text t,
                                              input logic [3:0] len);
        logic [63:0] h;
        h = 64'd0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                h[63 - 8 * i -: 8] = t[i];
            end
        end
        return h;
    endfunction

    function automatic logic [39:0] pack_tail(input edid_bp_pkg::t_text t,
                                              input logic [3:0] len);
        logic [39:0] tl;
        tl = 40'd0;
        for (int i = 8; i < edid_bp_pkg::TEXT_LEN; i++) begin
            if (4'(i) < len) begin
                tl[39 - 8 * (i - 8) -: 8] = t[i];
            end
        end
        return tl;
    endfunction

    function automatic logic [11:0] times_ten(input logic [7:0] b);
        return 12'({b, 3'b000}) + 12'({b, 1'b0});
    endfunction

    assign w_ok         = i_snap.full_ok;
    assign w_name_cnt   = w_ok ? i_snap.name_cnt : 4'd0;
    assign w_serial_cnt = w_ok ? i_snap.serial_cnt : 4'd0;

    always_comb begin
        n_result               = r_result;
        n_valid                = r_valid && !i_ready;
        if (i_load) begin
            n_valid                = 1'b1;
            n_result.header_ok     = w_ok;
            // each letter is a five bit code plus 0x40
            n_result.maker_letters = w_ok ? {3'b010, i_snap.maker_raw[14:10],
                                             3'b010, i_snap.maker_raw[9:5],
                                             3'b010, i_snap.maker_raw[4:0]} : 24'd0;
            n_result.width_mm      = w_ok ? times_ten(i_snap.size_raw[15:8]) : 12'd0;
            n_result.height_mm     = w_ok ? times_ten(i_snap.size_raw[7:0]) : 12'd0;
            n_result.name_found    = w_ok && i_snap.name_found;
            n_result.name_head     = pack_head(i_snap.name_text, w_name_cnt);
            n_result.name_tail     = pack_tail(i_snap.name_text, w_name_cnt);
            n_result.name_length   = w_name_cnt;
            n_result.serial_found  = w_ok && i_snap.serial_found;
            n_result.serial_head   = pack_head(i_snap.serial_text, w_serial_cnt);
            n_result.serial_tail   = pack_tail(i_snap.serial_text, w_serial_cnt);
            n_result.serial_length = w_serial_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== design/edid_base_block_parser_top.sv =====
// top level of the edid base block parser: input register, scan and result stage
//
//  port group  dir  tdata / tuser / tlast
//  s_axis      in   tdata[7:0] edid_byte, tlast last_byte
//  m_axis      out  tdata: one summary per blob, fields listed at the port
//
// one byte per cycle unless a summary waits; input register feeds the scan logic
// a summary is loaded into the result register when the final byte is processed
// i_rst_n is synchronous; after reset, and after every final byte, parsing
// restarts at byte zero
// a waiting summary holds the next final byte in the input register, which then
// stalls the input until the summary transfer
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module edid_base_block_parser_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [7:0]   i_s_axis_tdata,   // [7:0] edid_byte
    input  wire logic         i_s_axis_tlast,   // last_byte
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [0] header_ok, [24:1] maker_letters, [36:25] width_mm, [48:37] height_mm,
    // [49] name_found, [113:50] name_head, [153:114] name_tail,
    // [157:154] name_length, [158] serial_found, [222:159] serial_head,
    // [262:223] serial_tail, [266:263] serial_length, [271:267] zero
    output logic [8*edid_bp_pkg::OUT_BYTES-1:0] o_m_axis_tdata
);

    logic                  r_in_valid, n_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic                  w_process;
    logic                  w_load;
    logic                  w_s_ready;
    logic                  w_out_valid;
    edid_bp_pkg::t_snap    w_snap;
    edid_bp_pkg::t_result  w_res;

    assign w_process  = r_in_valid && (!r_in_last || !w_out_valid || i_m_axis_tready);
    assign w_load     = w_process && r_in_last;
    assign w_s_ready  = !r_in_valid || w_process;
    assign n_in_valid = (i_s_axis_tvalid && w_s_ready) || (r_in_valid && !w_process);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_ready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    edid_bp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_process),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_snap  (w_snap)
    );

    edid_bp_fmt u_fmt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_ready  (i_m_axis_tready),
        .i_snap   (w_snap),
        .o_valid  (w_out_valid),
        .o_result (w_res)
    );

    assign o_s_axis_tready = w_s_ready;
    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = {5'd0,
                              w_res.serial_length, w_res.serial_tail, w_res.serial_head,
                              w_res.serial_found,
                              w_res.name_length, w_res.name_tail, w_res.name_head,
                              w_res.name_found,
                              w_res.height_mm, w_res.width_mm, w_res.maker_letters,
                              w_res.header_ok};

    `ASSERT_IMPLIES(a_bad_is_zero, i_clk, i_rst_n,
                    o_m_axis_tvalid && !o_m_axis_tdata[0], o_m_axis_tdata == '0)
    `ASSERT_IMPLIES(a_len_range, i_clk, i_rst_n, o_m_axis_tvalid,
                    o_m_axis_tdata[157:154] <= 4'd13 && o_m_axis_tdata[266:263] <= 4'd13)
    `ASSERT_NEXT(a_in_kept, i_clk, i_rst_n, r_in_valid && !w_process,
                 r_in_valid && $stable(r_in_byte) && $stable(r_in_last))

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for the edid base block parser: table of directed blobs, random blobs, predictor check
`timescale 1ns / 1ps

module testbench;
    import edid_bp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_GAP     = 18;
    localparam int DATA_BITS   = 8 * OUT_BYTES;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam t_result SUM_EMPTY = '0;
    localparam t_result SUM_ONES  = '{header_ok: 1'b1, maker_letters: 24'h5F5F5F,
                                      width_mm: 12'd2550, height_mm: 12'd2550, default: '0};
    localparam t_result SUM_ZEROS = '{header_ok: 1'b1, maker_letters: 24'h404040,
                                      default: '0};

    typedef enum {BLOB_GOOD, BLOB_BAD_HDR0, BLOB_BAD_HDR1, BLOB_ONES, BLOB_ZEROS,
                  BLOB_NOISE} blob_e;
    typedef enum {SLOT_NAME, SLOT_SERIAL, SLOT_OTHER, SLOT_BROKEN, SLOT_NOISE} slot_e;
    typedef enum {TXT_LF_PAD, TXT_FULL, TXT_ZERO_CUT, TXT_BLANK, TXT_WS_TRAIL,
                  TXT_NOISE} text_e;

    typedef struct {
        blob_e   kind;
        int      len;
        slot_e   s0, s1, s2, s3;
        text_e   style;
        bit      typed;
        t_result want;
    } row_t;

    localparam int N_ROWS = 17;
    row_t rows [N_ROWS] = '{
        '{BLOB_GOOD,     1,   SLOT_NAME,   SLOT_SERIAL, SLOT_OTHER,  SLOT_OTHER,
          TXT_LF_PAD,   1'b1, SUM_EMPTY},
        '{BLOB_GOOD,     127, SLOT_NAME,   SLOT_SERIAL, SLOT_NAME,   SLOT_SERIAL,
          TXT_LF_PAD,   1'b1, SUM_EMPTY},
        '{BLOB_GOOD,     54,  SLOT_NAME,   SLOT_OTHER,  SLOT_OTHER,  SLOT_OTHER,
          TXT_FULL,     1'b1, SUM_EMPTY},
        '{BLOB_BAD_HDR0, 128, SLOT_NAME,   SLOT_SERIAL, SLOT_OTHER,  SLOT_OTHER,
          TXT_LF_PAD,   1'b1, SUM_EMPTY},
        '{BLOB_BAD_HDR1, 128, SLOT_SERIAL, SLOT_NAME,   SLOT_OTHER,  SLOT_OTHER,
          TXT_FULL,     1'b1, SUM_EMPTY},
        '{BLOB_ONES,     128, SLOT_NOISE,  SLOT_NOISE,  SLOT_NOISE,  SLOT_NOISE,
          TXT_NOISE,    1'b1, SUM_ONES},
        '{BLOB_ZEROS,    128, SLOT_NOISE,  SLOT_NOISE,  SLOT_NOISE,  SLOT_NOISE,
          TXT_NOISE,    1'b1, SUM_ZEROS},
        '{BLOB_GOOD,     128, SLOT_NAME,   SLOT_OTHER,  SLOT_OTHER,  SLOT_OTHER,
          TXT_LF_PAD,   1'b0, SUM_EMPTY},
        '{BLOB_GOOD,     128, SLOT_OTHER,  SLOT_OTHER,  SLOT_OTHER,  SLOT_SERIAL,
          TXT_FULL,     1'b0, SUM_EMPTY},
        '{BLOB_GOOD,     128, SLOT_SERIAL, SLOT_NAME,   SLOT_OTHER,  SLOT_OTHER,
          TXT_ZERO_CUT, 1'b0, SUM_EMPTY},
        '{BLOB_GOOD,     128, SLOT_NAME,   SLOT_OTHER,  SLOT_NAME,   SLOT_OTHER,
          TXT_BLANK,    1'b0, SUM_EMPTY},
        '{BLOB_GOOD,     200, SLOT_SERIAL, SLOT_SERIAL, SLOT_NOISE,  SLOT_NAME,
          TXT_WS_TRAIL, 1'b0, SUM_EMPTY},
        '{BLOB_GOOD,     128, SLOT_BROKEN, SLOT_BROKEN, SLOT_OTHER,  SLOT_NOISE,
          TXT_FULL,     1'b0, SUM_EMPTY},
        '{BLOB_NOISE,    128, SLOT_NOISE,  SLOT_NOISE,  SLOT_NOISE,  SLOT_NOISE,
          TXT_NOISE,    1'b0, SUM_EMPTY},
        '{BLOB_GOOD,     129, SLOT_NAME,   SLOT_SERIAL, SLOT_NAME,   SLOT_SERIAL,
          TXT_NOISE,    1'b0, SUM_EMPTY},
        '{BLOB_GOOD,     255, SLOT_NAME,   SLOT_SERIAL, SLOT_SERIAL, SLOT_NAME,
          TXT_ZERO_CUT, 1'b0, SUM_EMPTY},
        '{BLOB_GOOD,     2,   SLOT_NAME,   SLOT_NAME,   SLOT_NAME,   SLOT_NAME,
          TXT_FULL,     1'b1, SUM_EMPTY}
    };

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [7:0]           i_s_axis_tdata  = 8'h00;
    logic                 i_s_axis_tlast  = 1'b0;
    logic                 i_m_axis_tready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [DATA_BITS-1:0] o_m_axis_tdata;

    edid_base_block_parser_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // parser state of the predictor
    int          seen_bytes;
    logic        header_good;
    logic [15:0] maker_code;
    logic [15:0] size_cm;
    t_kind       desc_kind;
    t_text       desc_chars;
    t_text       name_chars;
    t_text       serial_chars;
    logic        name_seen;
    logic        serial_seen;
    logic [3:0]  name_keep;
    logic [3:0]  serial_keep;

    t_result summary_q [$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;

    logic [7:0] blob [256];
    slot_e      plan_slot [4];
    text_e      plan_text [4];
    bit         tx_quiet  = 1'b0;
    bit         hold_req  = 1'b0;
    int         hold_left = 0;
    int         rx_wait   = 0;

    task automatic clear_parser();
        seen_bytes   = 0;
        header_good  = 1'b0;
        maker_code   = '0;
        size_cm      = '0;
        desc_kind    = KIND_NONE;
        desc_chars   = '0;
        name_chars   = '0;
        serial_chars = '0;
        name_seen    = 1'b0;
        serial_seen  = 1'b0;
        name_keep    = '0;
        serial_keep  = '0;
    endtask

    function automatic logic [3:0] trimmed_length(input t_text t);
        int n;
        n = 0;
        while (n < TEXT_LEN && t[n] != CH_NUL) n++;
        while (n > 0 && (t[n-1] == CH_SPACE || t[n-1] == CH_LF || t[n-1] == CH_CR)) n--;
        return 4'(n);
    endfunction

    // characters at or past the kept length read as zero; character 0 on top
    function automatic logic [8*TEXT_LEN-1:0] visible_text(input t_text t, input logic [3:0] len);
        logic [8*TEXT_LEN-1:0] v;
        v = '0;
        for (int i = 0; i < TEXT_LEN; i++)
            v = {v[8*TEXT_LEN-9:0], (i < len) ? t[i] : CH_NUL};
        return v;
    endfunction

    function automatic logic [7:0] maker_letter(input logic [4:0] code);
        return 8'h40 + {3'b000, code};
    endfunction

    task automatic summarize_byte(input logic [7:0] b, input logic last,
                                  output bit emit, output t_result res);
        int                    d;
        logic [3:0]            len;
        logic [8*TEXT_LEN-1:0] v;
        if (seen_bytes < BLOCK_LEN) begin
            if (seen_bytes == 0)
                header_good = (b == HDR_BYTE0);
            else if (seen_bytes == 1)
                header_good = header_good && (b == HDR_BYTE1);
            else if (seen_bytes == 8)
                maker_code[15:8] = b;
            else if (seen_bytes == 9)
                maker_code[7:0] = b;
            else if (seen_bytes == 21)
                size_cm[15:8] = b;
            else if (seen_bytes == 22)
                size_cm[7:0] = b;

            if (seen_bytes >= DESC_START && seen_bytes < DESC_END) begin
                d = (seen_bytes - DESC_START) % DESC_SIZE;
                if (d == 0) begin
                    if (b == 8'h00) desc_kind = KIND_PREFIX;
                    else desc_kind = KIND_NONE;
                end else if (d < 3) begin
                    if (!(desc_kind == KIND_PREFIX && b == 8'h00)) desc_kind = KIND_NONE;
                end else if (d == 3) begin
                    if (desc_kind == KIND_PREFIX && b == TAG_NAME) desc_kind = KIND_NAME;
                    else if (desc_kind == KIND_PREFIX && b == TAG_SERIAL) desc_kind = KIND_SERIAL;
                    else desc_kind = KIND_NONE;
                end else if (d >= TEXT_OFS) begin
                    desc_chars[d - TEXT_OFS] = b;
                    if (d == DESC_SIZE - 1) begin
                        len = trimmed_length(desc_chars);
                        if (desc_kind == KIND_NAME) begin
                            name_chars = desc_chars;
                            name_seen  = 1'b1;
                            name_keep  = len;
                        end else if (desc_kind == KIND_SERIAL) begin
                            serial_chars = desc_chars;
                            serial_seen  = 1'b1;
                            serial_keep  = len;
                        end
                        desc_kind = KIND_NONE;
                    end
                end
            end
            seen_bytes++;
        end

        emit = last;
        res  = '0;
        if (last) begin
            if (seen_bytes >= BLOCK_LEN && header_good) begin
                res.header_ok     = 1'b1;
                res.maker_letters = {maker_letter(maker_code[14:10]),
                                     maker_letter(maker_code[9:5]),
                                     maker_letter(maker_code[4:0])};
                res.width_mm      = 12'(size_cm[15:8]) * 12'd10;
                res.height_mm     = 12'(size_cm[7:0]) * 12'd10;
                res.name_found    = name_seen;
                v                 = visible_text(name_chars, name_keep);
                res.name_head     = v[103:40];
                res.name_tail     = v[39:0];
                res.name_length   = name_keep;
                res.serial_found  = serial_seen;
                v                 = visible_text(serial_chars, serial_keep);
                res.serial_head   = v[103:40];
                res.serial_tail   = v[39:0];
                res.serial_length = serial_keep;
            end
            clear_parser();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch %0s: got %h, want %h", what, got, want);
    endtask

    task automatic check_summary(input logic [DATA_BITS-1:0] d, input t_result want);
        t_result got;
        got.header_ok     = d[0];
        got.maker_letters = d[24:1];
        got.width_mm      = d[36:25];
        got.height_mm     = d[48:37];
        got.name_found    = d[49];
        got.name_head     = d[113:50];
        got.name_tail     = d[153:114];
        got.name_length   = d[157:154];
        got.serial_found  = d[158];
        got.serial_head   = d[222:159];
        got.serial_tail   = d[262:223];
        got.serial_length = d[266:263];
        if (got.header_ok !== want.header_ok)
            report_mismatch("header_ok", 64'(got.header_ok), 64'(want.header_ok));
        if (got.maker_letters !== want.maker_letters)
            report_mismatch("maker_letters", 64'(got.maker_letters), 64'(want.maker_letters));
        if (got.width_mm !== want.width_mm)
            report_mismatch("width_mm", 64'(got.width_mm), 64'(want.width_mm));
        if (got.height_mm !== want.height_mm)
            report_mismatch("height_mm", 64'(got.height_mm), 64'(want.height_mm));
        if (got.name_found !== want.name_found)
            report_mismatch("name_found", 64'(got.name_found), 64'(want.name_found));
        if (got.name_head !== want.name_head)
            report_mismatch("name_head", got.name_head, want.name_head);
        if (got.name_tail !== want.name_tail)
            report_mismatch("name_tail", 64'(got.name_tail), 64'(want.name_tail));
        if (got.name_length !== want.name_length)
            report_mismatch("name_length", 64'(got.name_length), 64'(want.name_length));
        if (got.serial_found !== want.serial_found)
            report_mismatch("serial_found", 64'(got.serial_found), 64'(want.serial_found));
        if (got.serial_head !== want.serial_head)
            report_mismatch("serial_head", got.serial_head, want.serial_head);
        if (got.serial_tail !== want.serial_tail)
            report_mismatch("serial_tail", 64'(got.serial_tail), 64'(want.serial_tail));
        if (got.serial_length !== want.serial_length)
            report_mismatch("serial_length", 64'(got.serial_length), 64'(want.serial_length));
        if (d[DATA_BITS-1:OUT_BITS] !== '0)
            report_mismatch("pad bits", 64'(d[DATA_BITS-1:OUT_BITS]), 64'(0));
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    task automatic fill_text(input int base, input text_e st);
        int n;
        case (st)
            TXT_LF_PAD: begin
                n = $urandom_range(0, TEXT_LEN - 1);
                for (int i = 0; i < TEXT_LEN; i++)
                    blob[base+i] = (i < n) ? 8'($urandom_range(8'h20, 8'h7E))
                                 : (i == n) ? CH_LF : CH_SPACE;
            end
            TXT_FULL: begin
                for (int i = 0; i < TEXT_LEN; i++)
                    blob[base+i] = 8'($urandom_range(8'h21, 8'h7E));
            end
            TXT_ZERO_CUT: begin
                for (int i = 0; i < TEXT_LEN; i++)
                    blob[base+i] = 8'($urandom_range(1, 255));
                blob[base + $urandom_range(0, TEXT_LEN - 1)] = CH_NUL;
            end
            TXT_BLANK: begin
                for (int i = 0; i < TEXT_LEN; i++)
                    blob[base+i] = pick_blank();
            end
            TXT_WS_TRAIL: begin
                n = $urandom_range(1, TEXT_LEN - 1);
                for (int i = 0; i < TEXT_LEN; i++)
                    blob[base+i] = (i < n) ? 8'($urandom_range(8'h21, 8'h7E)) : pick_blank();
            end
            default: begin
                for (int i = 0; i < TEXT_LEN; i++)
                    blob[base+i] = 8'($urandom_range(0, 255));
            end
        endcase
    endtask

    task automatic fill_slot(input int k, input slot_e s, input text_e st);
        int o;
        o = DESC_START + k * DESC_SIZE;
        for (int i = 0; i < DESC_SIZE; i++)
            blob[o+i] = 8'($urandom_range(0, 255));
        if (s != SLOT_NOISE) begin
            blob[o]   = 8'h00;
            blob[o+1] = 8'h00;
            blob[o+2] = 8'h00;
            case (s)
                SLOT_NAME:   blob[o+3] = TAG_NAME;
                SLOT_SERIAL: blob[o+3] = TAG_SERIAL;
                SLOT_OTHER:  blob[o+3] = 8'($urandom_range(0, 251));
                default: begin
                    // broken zero prefix in front of a real tag
                    blob[o+3] = ($urandom_range(0, 1) == 0) ? TAG_NAME : TAG_SERIAL;
                    blob[o + $urandom_range(0, 2)] = 8'($urandom_range(1, 255));
                end
            endcase
            fill_text(o + TEXT_OFS, st);
        end
    endtask

    task automatic build_blob(input blob_e kind);
        for (int i = 0; i < 256; i++)
            blob[i] = 8'($urandom_range(0, 255));
        blob[0] = HDR_BYTE0;
        for (int i = 1; i < 7; i++)
            blob[i] = 8'hFF;
        blob[7] = 8'h00;
        for (int k = 0; k < 4; k++)
            fill_slot(k, plan_slot[k], plan_text[k]);
        case (kind)
            BLOB_BAD_HDR0: blob[0] = 8'($urandom_range(1, 255));
            BLOB_BAD_HDR1: blob[1] = 8'($urandom_range(0, 254));
            BLOB_ONES: begin
                for (int i = 0; i < 256; i++) blob[i] = 8'hFF;
                blob[0] = HDR_BYTE0;
            end
            BLOB_ZEROS: begin
                for (int i = 0; i < 256; i++) blob[i] = 8'h00;
                blob[1] = HDR_BYTE1;
            end
            BLOB_NOISE: begin
                for (int i = 0; i < 256; i++) blob[i] = 8'($urandom_range(0, 255));
            end
            default: ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
                             input t_result want);
        int      gap;
        bit      emit;
        t_result res;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        summarize_byte(b, last, emit, res);
        if (emit) summary_q.insert(summary_q.size(), typed ? want : res);
    endtask

    task automatic send_blob(input int len, input bit typed, input t_result want);
        for (int i = 0; i < len; i++)
            push_byte(blob[i], i == len - 1, typed, want);
    endtask

    function automatic slot_e pick_slot();
        case ($urandom_range(0, 9))
            0, 1, 2: return SLOT_NAME;
            3, 4, 5: return SLOT_SERIAL;
            6:       return SLOT_OTHER;
            7:       return SLOT_BROKEN;
            default: return SLOT_NOISE;
        endcase
    endfunction

    function automatic text_e pick_text();
        case ($urandom_range(0, 5))
            0:       return TXT_LF_PAD;
            1:       return TXT_FULL;
            2:       return TXT_ZERO_CUT;
            3:       return TXT_BLANK;
            4:       return TXT_WS_TRAIL;
            default: return TXT_NOISE;
        endcase
    endfunction

    // receiver: per-summary wait plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (!i_rst_n) begin
                i_m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (summary_q.size() == 0)
                report_mismatch("unexpected summary transfer", 64'(0), 64'(0));
            else
                check_summary(o_m_axis_tdata, summary_q.pop_front());
            rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int    rand_items;
        int    rand_blobs;
        int    len;
        int    sel;
        blob_e kind;
        clear_parser();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            plan_slot[0] = rows[r].s0;
            plan_slot[1] = rows[r].s1;
            plan_slot[2] = rows[r].s2;
            plan_slot[3] = rows[r].s3;
            for (int k = 0; k < 4; k++) plan_text[k] = rows[r].style;
            build_blob(rows[r].kind);
            tx_quiet = (r % 3 == 0);
            send_blob(rows[r].len, rows[r].typed, rows[r].want);
        end

        // output held off while short blobs keep coming, so the input backs up
        tx_quiet = 1'b1;
        hold_req = 1'b1;
        for (int n = 0; n < 6; n++) begin
            for (int k = 0; k < 4; k++) begin
                plan_slot[k] = pick_slot();
                plan_text[k] = pick_text();
            end
            build_blob(BLOB_GOOD);
            send_blob($urandom_range(1, 4), 1'b1, SUM_EMPTY);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        wait (summary_q.size() == 0);

        rand_items = 0;
        rand_blobs = 0;
        while (rand_items < 500 || rand_blobs < 4) begin
            for (int k = 0; k < 4; k++) begin
                plan_slot[k] = pick_slot();
                plan_text[k] = pick_text();
            end
            kind = BLOB_GOOD;
            len  = BLOCK_LEN;
            sel  = $urandom_range(0, 19);
            case (sel)
                11, 12:  len = $urandom_range(BLOCK_LEN + 1, 255);
                13, 14:  len = $urandom_range(1, BLOCK_LEN - 1);
                15:      len = $urandom_range(1, 3);
                16:      kind = BLOB_BAD_HDR0;
                17:      kind = BLOB_BAD_HDR1;
                18:      kind = BLOB_NOISE;
                19:      kind = ($urandom_range(0, 1) == 0) ? BLOB_ONES : BLOB_ZEROS;
                default: ;
            endcase
            build_blob(kind);
            tx_quiet = ($urandom_range(0, 3) == 0);
            send_blob(len, 1'b0, SUM_EMPTY);
            rand_items += len;
            rand_blobs++;
            if (rand_blobs == 2) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                wait (summary_q.size() == 0);
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        wait (summary_q.size() == 0);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && summary_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/edid_bp_pkg.sv
design/edid_bp_scan.sv
design/edid_bp_fmt.sv
design/edid_base_block_parser_top.sv
tb/testbench.sv
